// ----- rtl/rmts_pkg.sv -----
package rmts_pkg;

  // Task table size and derived widths.
  localparam int NUM_TASKS = 8;
  localparam int IDX_W     = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int CNT_W     = $clog2(NUM_TASKS + 1);
  localparam int CHOICE_W  = $clog2(NUM_TASKS + 2);

  // Choice codes beyond the task indexes.
  localparam logic [CHOICE_W-1:0] CHOICE_IDLE = CHOICE_W'(NUM_TASKS);
  localparam logic [CHOICE_W-1:0] CHOICE_NONE = CHOICE_W'(NUM_TASKS + 1);

  // Input kinds.
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_LOAD = 1'b1;

  // Field widths and stream packing.
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  typedef struct packed {
    logic [15:0] burst;
    logic [15:0] period;
    logic [15:0] remaining;
    logic [15:0] phase;
  } task_entry_t;

endpackage

// ----- rtl/rate_monotonic_task_scheduler.sv -----
// Rate-monotonic scheduler over a table of rmts_pkg::NUM_TASKS periodic tasks.
// A load transfer (in_tuser = 1) writes one task's burst and period and restarts
// time: tick counter and every task's phase and remaining work go back to zero,
// and the switch marker is cleared; it produces no result. A tick transfer
// (in_tuser = 0) releases every enabled task whose phase is zero, runs the
// ready task with the smallest period (lowest index on ties), and returns one
// result: the tick number, the chosen task or idle, and whether the choice
// changed (always on the first tick after reset or a load). A period of zero
// disables a task. The task table sits in one synchronous memory, and one
// read-modify-write sweep visits one entry per cycle, followed by a write-back
// of the chosen task's decremented work and the result hand-off. The result
// register parts the two sides: the next item is taken while a result still
// waits for out_tready.
module rate_monotonic_task_scheduler (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [2:0] task_index, [18:3] burst, [34:19] period, [39:35] zero
  input  logic [rmts_pkg::IN_DATA_W-1:0]   in_tdata,
  // kind
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [31:0] time_res, [34:32] running_task, [35] switched, [39:36] zero
  output logic [rmts_pkg::OUT_DATA_W-1:0]  out_tdata,
  // idle
  output logic                             out_tuser
);
  import rmts_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIX, S_OUT} state_t;

  // Task table: one write port, one registered read port.
  task_entry_t mem [NUM_TASKS];
  task_entry_t rd_data_r;

  state_t               state_r;
  logic [CNT_W-1:0]     issue_r;       // next entry to read
  logic                 rd_vld_r;      // rd_data_r holds an entry to process
  logic [IDX_W-1:0]     rd_idx_r;
  logic [NUM_TASKS-1:0] cfg_valid_r;   // burst/period written since reset
  logic [NUM_TASKS-1:0] dyn_valid_r;   // remaining/phase written since restart
  logic                 found_r;
  logic [IDX_W-1:0]     best_idx_r;
  task_entry_t          best_ent_r;
  logic [31:0]          tick_r;
  logic [CHOICE_W-1:0]  last_choice_r;
  logic                 out_tvalid_r;
  logic [31:0]          out_time_r;
  logic [2:0]           out_task_r;
  logic                 out_idle_r;
  logic                 out_sw_r;

  logic                 in_fire;
  logic [2:0]           ld_idx;
  logic                 ld_in_range;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_wa;
  task_entry_t          mem_wd;
  logic                 issue_go;
  task_entry_t          cur;           // entry read, with invalid fields masked
  task_entry_t          upd;           // entry after release and phase advance
  logic [16:0]          phase_inc;
  logic                 pick;
  logic [CHOICE_W-1:0]  choice;
  logic                 out_free;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign ld_idx    = in_tdata[2:0];
  assign ld_in_range = (32'(ld_idx) < NUM_TASKS);
  assign issue_go  = (state_r == S_SCAN) && (32'(issue_r) < NUM_TASKS);
  assign out_free  = !out_tvalid_r || out_tready;

  // Mask out entries that reset or restart has logically cleared.
  always_comb begin
    cur = rd_data_r;
    if (!cfg_valid_r[rd_idx_r]) begin
      cur.burst  = '0;
      cur.period = '0;
    end
    if (!dyn_valid_r[rd_idx_r]) begin
      cur.remaining = '0;
      cur.phase     = '0;
    end
  end

  // Release on phase zero, then advance the phase counter.
  always_comb begin
    upd       = cur;
    phase_inc = {1'b0, cur.phase} + 17'd1;
    if (cur.period != '0) begin
      if (cur.phase == '0) begin
        upd.remaining = cur.burst;
      end
      if (phase_inc >= {1'b0, cur.period}) begin
        upd.phase = '0;
      end else begin
        upd.phase = phase_inc[15:0];
      end
    end
    pick = (upd.remaining != '0) && (!found_r || (upd.period < best_ent_r.period));
  end

  // Single write port: load, sweep write-back, or chosen-task decrement.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = rd_idx_r;
    mem_wd = upd;
    if (in_fire && (in_tuser == KIND_LOAD)) begin
      mem_we = ld_in_range;
      mem_wa = IDX_W'(ld_idx);
      mem_wd = '{burst: in_tdata[18:3], period: in_tdata[34:19],
                 remaining: 16'd0, phase: 16'd0};
    end else if ((state_r == S_SCAN) && rd_vld_r) begin
      mem_we = 1'b1;
    end else if (state_r == S_FIX) begin
      mem_we = found_r;
      mem_wa = best_idx_r;
      mem_wd = best_ent_r;
      mem_wd.remaining = best_ent_r.remaining - 16'd1;
    end
  end

  assign choice = found_r ? CHOICE_W'(best_idx_r) : CHOICE_IDLE;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (issue_go) begin
      rd_data_r <= mem[issue_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      issue_r       <= '0;
      rd_vld_r      <= 1'b0;
      rd_idx_r      <= '0;
      cfg_valid_r   <= '0;
      dyn_valid_r   <= '0;
      found_r       <= 1'b0;
      best_idx_r    <= '0;
      tick_r        <= '0;
      last_choice_r <= CHOICE_NONE;
      out_tvalid_r  <= 1'b0;
    end else begin
      // Drop the result once taken; the hand-off state reloads it itself.
      if (out_tvalid_r && out_tready && (state_r != S_OUT)) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (in_tuser == KIND_LOAD) begin
              // Restart time; write the entry only when the index exists.
              if (ld_in_range) begin
                cfg_valid_r[IDX_W'(ld_idx)] <= 1'b1;
              end
              dyn_valid_r   <= '0;
              tick_r        <= '0;
              last_choice_r <= CHOICE_NONE;
            end else begin
              issue_r  <= '0;
              rd_vld_r <= 1'b0;
              found_r  <= 1'b0;
              state_r  <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // Read one entry per cycle, process the one read last cycle.
          rd_vld_r <= issue_go;
          if (issue_go) begin
            rd_idx_r <= issue_r[IDX_W-1:0];
            issue_r  <= issue_r + CNT_W'(1);
          end
          if (rd_vld_r) begin
            cfg_valid_r[rd_idx_r] <= 1'b1;
            dyn_valid_r[rd_idx_r] <= 1'b1;
            if (pick) begin
              found_r    <= 1'b1;
              best_idx_r <= rd_idx_r;
              best_ent_r <= upd;
            end
            if (32'(rd_idx_r) == NUM_TASKS - 1) begin
              state_r <= S_FIX;
            end
          end
        end
        S_FIX: begin
          state_r <= S_OUT;
        end
        S_OUT: begin
          // Hold until the result register is free.
          if (out_free) begin
            out_tvalid_r  <= 1'b1;
            out_time_r    <= tick_r;
            out_task_r    <= found_r ? 3'(best_idx_r) : 3'd0;
            out_idle_r    <= !found_r;
            out_sw_r      <= (choice != last_choice_r);
            last_choice_r <= choice;
            tick_r        <= tick_r + 32'd1;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {4'd0, out_sw_r, out_task_r, out_time_r};
  assign out_tuser  = out_idle_r;

endmodule

// ----- tb/rate_monotonic_task_scheduler_tb.sv -----
module rate_monotonic_task_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rmts_pkg::*;

  localparam int HALF_PERIOD    = 1;
  localparam int TARGET_ITEMS   = 1850;
  localparam int PERIOD_CEILING = 999999;
  // A tick sweeps the whole task table, then writes back and hands off.
  localparam int TICK_CYCLES    = NUM_TASKS + 4;
  localparam int DRAIN_CYCLES   = 2 * TICK_CYCLES;
  // Longest legal quiet stretch is one tick plus a sender gap plus a receiver
  // stall; take it many times over.
  localparam int WATCHDOG_LIMIT = 1000;

  // One input transfer: a time tick or a task-entry load.
  typedef struct {
    logic        kind;
    logic [2:0]  task_index;
    logic [15:0] burst;
    logic [15:0] period;
  } sched_item_t;

  // One result transfer: what ran on a given tick.
  typedef struct {
    logic [31:0] time_res;
    logic [2:0]  running_task;
    logic        idle;
    logic        switched;
  } dispatch_t;

  // Tracks the task table and the timebase, and holds the dispatches still due.
  class rmts_schedule_tracker;
    bit [15:0]           burst_tab[NUM_TASKS];
    bit [15:0]           period_tab[NUM_TASKS];
    bit [15:0]           remaining_tab[NUM_TASKS];
    bit [15:0]           phase_tab[NUM_TASKS];
    bit [31:0]           tick_count;
    bit [CHOICE_W-1:0]   last_pick;
    dispatch_t           dispatch_q[$];
    int                  mismatches;

    function new();
      clear_timebase();
    endfunction

    // A load restarts time but keeps the burst and period entries.
    function void clear_timebase();
      for (int i = 0; i < NUM_TASKS; i++) begin
        remaining_tab[i] = '0;
        phase_tab[i]     = '0;
      end
      tick_count = '0;
      last_pick  = CHOICE_NONE;
    endfunction

    function void note_item(sched_item_t it);
      dispatch_t         res;
      bit [CHOICE_W-1:0] pick;
      int                best;
      if (it.kind == KIND_LOAD) begin
        if (int'(it.task_index) < NUM_TASKS) begin
          burst_tab[it.task_index]  = it.burst;
          period_tab[it.task_index] = it.period;
        end
        clear_timebase();
        return;
      end
      // Release tasks at phase zero, then advance each enabled phase counter.
      for (int i = 0; i < NUM_TASKS; i++) begin
        if (period_tab[i] != 0) begin
          if (phase_tab[i] == 0)
            remaining_tab[i] = burst_tab[i];
          if (int'(phase_tab[i]) + 1 >= int'(period_tab[i]))
            phase_tab[i] = '0;
          else
            phase_tab[i] = phase_tab[i] + 16'd1;
        end
      end
      // Shortest period among ready tasks; strict compare keeps the lowest index.
      pick = CHOICE_IDLE;
      best = PERIOD_CEILING;
      for (int i = 0; i < NUM_TASKS; i++) begin
        if (remaining_tab[i] > 0 && int'(period_tab[i]) < best) begin
          best = int'(period_tab[i]);
          pick = CHOICE_W'(i);
        end
      end
      res.time_res     = tick_count;
      res.idle         = (pick == CHOICE_IDLE);
      res.running_task = (pick == CHOICE_IDLE) ? 3'd0 : pick[2:0];
      res.switched     = (pick != last_pick);
      last_pick = pick;
      if (pick != CHOICE_IDLE)
        remaining_tab[pick[2:0]] = remaining_tab[pick[2:0]] - 16'd1;
      tick_count = tick_count + 32'd1;
      dispatch_q.push_back(res);
    endfunction

    function void check_dispatch(dispatch_t got);
      dispatch_t want;
      if (dispatch_q.size() == 0) begin
        $error("unexpected result: time_res %0d running_task %0d idle %0d switched %0d",
               got.time_res, got.running_task, got.idle, got.switched);
        mismatches++;
        return;
      end
      want = dispatch_q.pop_front();
      if (got.time_res !== want.time_res) begin
        $error("time_res: expected %0d, got %0d", want.time_res, got.time_res);
        mismatches++;
      end
      if (got.running_task !== want.running_task) begin
        $error("running_task: expected %0d, got %0d", want.running_task, got.running_task);
        mismatches++;
      end
      if (got.idle !== want.idle) begin
        $error("idle: expected %0d, got %0d", want.idle, got.idle);
        mismatches++;
      end
      if (got.switched !== want.switched) begin
        $error("switched: expected %0d, got %0d", want.switched, got.switched);
        mismatches++;
      end
    endfunction

    function int pending();
      return dispatch_q.size();
    endfunction
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  // [2:0] task_index, [18:3] burst, [34:19] period, [39:35] zero
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  // kind
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [31:0] time_res, [34:32] running_task, [35] switched, [39:36] zero
  logic [OUT_DATA_W-1:0] out_tdata;
  // idle
  logic                  out_tuser;

  rmts_schedule_tracker sb;
  bit                   in_idle_on  = 1'b1;
  bit                   out_idle_on = 1'b1;
  int                   items_sent  = 0;
  int                   quiet_cycles = 0;

  rate_monotonic_task_scheduler DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic sched_item_t mk_item(logic kind, logic [2:0] idx,
                                          logic [15:0] burst, logic [15:0] period);
    sched_item_t it;
    it.kind       = kind;
    it.task_index = idx;
    it.burst      = burst;
    it.period     = period;
    return it;
  endfunction

  // Tick fields carry junk: the block must ignore them.
  function automatic sched_item_t rand_tick();
    return mk_item(KIND_TICK, 3'($urandom), 16'($urandom), 16'($urandom));
  endfunction

  // Tame loads keep periods short and bursts small so tasks contend often;
  // wide ones sweep the full field range.
  function automatic sched_item_t rand_load(bit tame, logic [2:0] idx);
    logic [15:0] burst;
    logic [15:0] period;
    if (tame) begin
      burst  = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 5));
      period = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 16));
    end else begin
      burst  = 16'($urandom);
      period = 16'($urandom);
    end
    return mk_item(KIND_LOAD, idx, burst, period);
  endfunction

  // Hold valid between back-to-back transfers; lower it only for a real gap.
  task automatic send_item(sched_item_t it);
    int gap;
    gap = in_idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.kind;
    in_tdata  <= {5'b0, it.period, it.burst, it.task_index};
    do @(posedge clk); while (!in_tready);
    sb.note_item(it);
    items_sent++;
  endtask

  task automatic send_ticks(int count);
    repeat (count) send_item(rand_tick());
  endtask

  // Result side: stall a random number of cycles per transfer, then take one.
  initial begin
    dispatch_t got;
    int        stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = out_idle_on ? $urandom_range(0, 6) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got.time_res     = out_tdata[31:0];
      got.running_task = out_tdata[34:32];
      got.switched     = out_tdata[35];
      got.idle         = out_tuser;
      sb.check_dispatch(got);
    end
  end

  // Watchdog: count cycles in which neither channel completes a transfer.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    int n_loads;
    int roll;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table: every tick is idle, only the first one counts as a switch.
    send_item(mk_item(KIND_TICK, 3'd0, 16'h0000, 16'h0000));
    send_item(mk_item(KIND_TICK, 3'd7, 16'hFFFF, 16'hFFFF));
    // Equal periods on tasks 7 and 3: task 3 must win the tie.
    send_item(mk_item(KIND_LOAD, 3'd7, 16'd2, 16'd4));
    send_item(mk_item(KIND_LOAD, 3'd3, 16'd1, 16'd4));
    // Zero burst: released with no work, never runs.
    send_item(mk_item(KIND_LOAD, 3'd5, 16'd0, 16'd2));
    // Period zero: disabled despite a nonzero burst.
    send_item(mk_item(KIND_LOAD, 3'd1, 16'd5, 16'd0));
    send_ticks(6);
    // Shorter period preempts the running tasks.
    send_item(mk_item(KIND_LOAD, 3'd2, 16'd3, 16'd2));
    send_ticks(5);
    // Extreme burst and period on the lowest entry.
    send_item(mk_item(KIND_LOAD, 3'd0, 16'hFFFF, 16'hFFFF));
    send_ticks(2);
    send_item(mk_item(KIND_LOAD, 3'd0, 16'd0, 16'd0));
    send_item(mk_item(KIND_LOAD, 3'd2, 16'd0, 16'd0));
    send_ticks(1);

    while (items_sent < TARGET_ITEMS) begin
      in_idle_on  = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      roll = $urandom_range(0, 99);
      if (roll < 80) begin
        // Well-formed: set up some entries, then let the schedule run.
        if ($urandom_range(0, 3) == 0) begin
          for (int i = 0; i < NUM_TASKS; i++)
            send_item(rand_load(1'b1, 3'(i)));
        end else begin
          n_loads = $urandom_range(1, 4);
          repeat (n_loads) send_item(rand_load(1'b1, 3'($urandom)));
        end
        send_ticks($urandom_range(8, 48));
      end else if (roll < 90) begin
        // Broken sequences: loads land mid-schedule and restart time.
        repeat ($urandom_range(5, 20)) begin
          if ($urandom_range(0, 2) == 0)
            send_item(rand_load(1'($urandom_range(0, 1)), 3'($urandom)));
          else
            send_item(rand_tick());
        end
      end else begin
        // Full-range entries, then a short run of ticks.
        repeat ($urandom_range(1, 3)) send_item(rand_load(1'b0, 3'($urandom)));
        send_ticks($urandom_range(2, 12));
      end
    end
    in_tvalid <= 1'b0;

    // Drain: wait for every due dispatch, then allow the block to settle.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/rmts_pkg.sv
rtl/rate_monotonic_task_scheduler.sv
tb/rate_monotonic_task_scheduler_tb.sv
